### hdl/osbms_pkg.sv
// shared types and constants for the overlap-safe block move splitter
// used by the controller, the datapath and the top level
package osbms_pkg;

    localparam int ADDR_BITS  = 48;
    localparam int MAX_PIECES = 64;
    localparam int MAX_BLOCKS = (MAX_PIECES - 2) / 2;

    localparam int BS_W      = 17;                    // block size, up to 65536
    localparam int OFF_W     = 16;                    // in-block offset
    localparam int LEN_W     = 21;                    // request byte count
    localparam int NUM_W     = ADDR_BITS + 1;         // address plus carry past the top
    localparam int MB_W      = $clog2(MAX_BLOCKS + 1);
    localparam int LIM_W     = BS_W + MB_W;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [BS_W-1:0] BS_RESET = BS_W'(4096);
    localparam logic [BS_W-1:0] BS_MAX   = BS_W'(65536);

    typedef enum logic [1:0] {
        ST_PIECE   = 2'd0,
        ST_NOTHING = 2'd1,
        ST_REJECT  = 2'd2
    } osbms_status_t;

    typedef struct packed {
        logic load;    // take a new request
        logic prep;    // classify and set up the dividends
        logic div;     // one restoring divide step
        logic step;    // advance past the shown piece
    } osbms_cmd_t;

    typedef struct packed {
        logic skip_div;  // request ends in a single status row
        logic last;      // shown result is the final one
    } osbms_sts_t;

endpackage

### hdl/overlap_safe_block_move_splitter_top.sv
// overlap-safe block move splitter: one request in, one result per cycle out
// while m_ready is high; after accept the request is classified, then 49 divide
// steps run before the first piece; status rows skip the divide steps; up to 63
// pieces follow; the next request is taken once the last result has been
// transferred
// reset (aresetn low, synchronous) idles the controller and sets block_size to 4096
module overlap_safe_block_move_splitter_top import osbms_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [BS_W-1:0]      cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ADDR_BITS-1:0] s_src_addr,
    input  logic [ADDR_BITS-1:0] s_dst_addr,
    input  logic [LEN_W-1:0]     s_byte_count,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic                 m_whole_block,
    output logic [ADDR_BITS-1:0] m_src_block,
    output logic [ADDR_BITS-1:0] m_dst_block,
    output logic [OFF_W-1:0]     m_src_ofs,
    output logic [OFF_W-1:0]     m_dst_ofs,
    output logic [BS_W-1:0]      m_piece_len,
    output logic                 m_last
);

    osbms_cmd_t cmd;
    osbms_sts_t sts;

    osbms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    osbms_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .sts           (sts),
        .s_src_addr    (s_src_addr),
        .s_dst_addr    (s_dst_addr),
        .s_byte_count  (s_byte_count),
        .m_status      (m_status),
        .m_whole_block (m_whole_block),
        .m_src_block   (m_src_block),
        .m_dst_block   (m_dst_block),
        .m_src_ofs     (m_src_ofs),
        .m_dst_ofs     (m_dst_ofs),
        .m_piece_len   (m_piece_len),
        .m_last        (m_last)
    );

endmodule

### hdl/osbms_ctrl.sv
// controller state machine for the block move splitter
// depends on osbms_pkg; drives the datapath by command struct
module osbms_ctrl import osbms_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  osbms_sts_t sts,
    output osbms_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.prep = 1'b1;
                cnt_next = '0;
                state_next = sts.skip_div ? S_OUT : S_DIV;
            end
            S_DIV: begin
                cmd.div  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(NUM_W - 1)) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    cmd.step = 1'b1;
                    if (sts.last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

endmodule

### hdl/osbms_dp.sv
// datapath for the block move splitter: request registers, two shared-step
// restoring dividers and the piece walker; depends on osbms_pkg
module osbms_dp import osbms_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [BS_W-1:0]      cfg_wdata,
    input  osbms_cmd_t           cmd,
    output osbms_sts_t           sts,
    input  logic [ADDR_BITS-1:0] s_src_addr,
    input  logic [ADDR_BITS-1:0] s_dst_addr,
    input  logic [LEN_W-1:0]     s_byte_count,
    output logic [1:0]           m_status,
    output logic                 m_whole_block,
    output logic [ADDR_BITS-1:0] m_src_block,
    output logic [ADDR_BITS-1:0] m_dst_block,
    output logic [OFF_W-1:0]     m_src_ofs,
    output logic [OFF_W-1:0]     m_dst_ofs,
    output logic [BS_W-1:0]      m_piece_len,
    output logic                 m_last
);

    logic [BS_W-1:0]      bs_reg, bs_next;
    logic [ADDR_BITS-1:0] src_reg, dst_reg;
    logic [LEN_W-1:0]     size_reg, size_next;
    logic [NUM_W-1:0]     sq_reg, sq_next, dq_reg, dq_next;
    logic [OFF_W-1:0]     sr_reg, sr_next, dr_reg, dr_next;
    logic                 back_reg, back_next;
    osbms_status_t        stat_reg, stat_next;

    // request classification
    logic [NUM_W-1:0] src_end, dst_end;
    logic [LIM_W-1:0] limit;
    logic             nothing, too_long, backward;

    // piece walker
    logic [BS_W-1:0] s_room, d_room, n, s_sum, d_sum;
    logic [OFF_W-1:0] s_off, d_off;
    logic             is_last;

    // divider steps
    logic [NUM_W+OFF_W-1:0] s_div, d_div;

    function automatic logic [NUM_W+OFF_W-1:0] div_step(
        input logic [NUM_W-1:0] num,
        input logic [OFF_W-1:0] rem,
        input logic [BS_W-1:0]  dvs
    );
        logic [BS_W-1:0] trial;
        logic            qbit;
        trial = {rem, num[NUM_W-1]};
        qbit  = (trial >= dvs);
        if (qbit) begin
            trial = trial - dvs;
        end
        return {num[NUM_W-2:0], qbit, trial[OFF_W-1:0]};
    endfunction

    always_comb begin
        src_end  = NUM_W'(src_reg) + NUM_W'(size_reg) - NUM_W'(1);
        dst_end  = NUM_W'(dst_reg) + NUM_W'(size_reg) - NUM_W'(1);
        limit    = LIM_W'(bs_reg) * LIM_W'(MAX_BLOCKS);
        nothing  = (size_reg == '0) || (src_reg == dst_reg);
        too_long = (LIM_W'(size_reg) > limit);
        backward = (src_reg < dst_reg) && (src_end >= NUM_W'(dst_reg));
    end

    always_comb begin
        if (back_reg) begin
            s_room = BS_W'(sr_reg) + BS_W'(1);
            d_room = BS_W'(dr_reg) + BS_W'(1);
        end else begin
            s_room = bs_reg - BS_W'(sr_reg);
            d_room = bs_reg - BS_W'(dr_reg);
        end
        n = (s_room < d_room) ? s_room : d_room;
        if (LEN_W'(n) > size_reg) begin
            n = BS_W'(size_reg);
        end
        if (back_reg) begin
            s_off = OFF_W'(s_room - n);
            d_off = OFF_W'(d_room - n);
        end else begin
            s_off = sr_reg;
            d_off = dr_reg;
        end
        s_sum   = BS_W'(sr_reg) + n;
        d_sum   = BS_W'(dr_reg) + n;
        is_last = (size_reg == LEN_W'(n));
        s_div   = div_step(sq_reg, sr_reg, bs_reg);
        d_div   = div_step(dq_reg, dr_reg, bs_reg);
    end

    always_comb begin
        bs_next   = bs_reg;
        size_next = size_reg;
        sq_next   = sq_reg;
        dq_next   = dq_reg;
        sr_next   = sr_reg;
        dr_next   = dr_reg;
        back_next = back_reg;
        stat_next = stat_reg;
        if (cfg_we) begin
            priority if (cfg_wdata == '0) begin
                bs_next = BS_W'(1);
            end else if (cfg_wdata > BS_MAX) begin
                bs_next = BS_MAX;
            end else begin
                bs_next = cfg_wdata;
            end
        end
        priority if (cmd.load) begin
            size_next = s_byte_count;
        end else if (cmd.prep) begin
            back_next = backward;
            sq_next   = backward ? src_end : NUM_W'(src_reg);
            dq_next   = backward ? dst_end : NUM_W'(dst_reg);
            sr_next   = '0;
            dr_next   = '0;
            priority if (nothing) begin
                stat_next = ST_NOTHING;
            end else if (too_long) begin
                stat_next = ST_REJECT;
            end else begin
                stat_next = ST_PIECE;
            end
        end else if (cmd.div) begin
            sq_next = s_div[NUM_W+OFF_W-1:OFF_W];
            sr_next = s_div[OFF_W-1:0];
            dq_next = d_div[NUM_W+OFF_W-1:OFF_W];
            dr_next = d_div[OFF_W-1:0];
        end else if (cmd.step) begin
            size_next = size_reg - LEN_W'(n);
            if (back_reg) begin
                // crossing below the block start wraps to the last byte of the block below
                if (n == s_room) begin
                    sr_next = OFF_W'(bs_reg - BS_W'(1));
                    sq_next = sq_reg - NUM_W'(1);
                end else begin
                    sr_next = OFF_W'(BS_W'(sr_reg) - n);
                end
                if (n == d_room) begin
                    dr_next = OFF_W'(bs_reg - BS_W'(1));
                    dq_next = dq_reg - NUM_W'(1);
                end else begin
                    dr_next = OFF_W'(BS_W'(dr_reg) - n);
                end
            end else begin
                if (s_sum == bs_reg) begin
                    sr_next = '0;
                    sq_next = sq_reg + NUM_W'(1);
                end else begin
                    sr_next = OFF_W'(s_sum);
                end
                if (d_sum == bs_reg) begin
                    dr_next = '0;
                    dq_next = dq_reg + NUM_W'(1);
                end else begin
                    dr_next = OFF_W'(d_sum);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bs_reg <= BS_RESET;
        end else begin
            bs_reg <= bs_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            src_reg <= s_src_addr;
            dst_reg <= s_dst_addr;
        end
        size_reg <= size_next;
        sq_reg   <= sq_next;
        dq_reg   <= dq_next;
        sr_reg   <= sr_next;
        dr_reg   <= dr_next;
        back_reg <= back_next;
        stat_reg <= stat_next;
    end

    assign sts.skip_div = nothing || too_long;
    assign sts.last     = (stat_reg != ST_PIECE) || is_last;

    always_comb begin
        m_status = stat_reg;
        if (stat_reg == ST_PIECE) begin
            m_whole_block = (s_off == '0) && (d_off == '0) && (n == bs_reg);
            m_src_block   = sq_reg[ADDR_BITS-1:0];
            m_dst_block   = dq_reg[ADDR_BITS-1:0];
            m_src_ofs     = s_off;
            m_dst_ofs     = d_off;
            m_piece_len   = n;
            m_last        = is_last;
        end else begin
            m_whole_block = 1'b0;
            m_src_block   = '0;
            m_dst_block   = '0;
            m_src_ofs     = '0;
            m_dst_ofs     = '0;
            m_piece_len   = '0;
            m_last        = 1'b1;
        end
    end

endmodule

### hdl/osbms_checker.sv
// port-level checks for the block move splitter, bound to the top level
// depends on osbms_pkg
module osbms_checker import osbms_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [1:0]           m_status,
    input logic                 m_whole_block,
    input logic [ADDR_BITS-1:0] m_src_block,
    input logic [ADDR_BITS-1:0] m_dst_block,
    input logic [OFF_W-1:0]     m_src_ofs,
    input logic [OFF_W-1:0]     m_dst_ofs,
    input logic [BS_W-1:0]      m_piece_len,
    input logic                 m_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_piece_len) && $stable(m_status)
            && $stable(m_whole_block) && $stable(m_src_block) && $stable(m_dst_block)
            && $stable(m_src_ofs) && $stable(m_dst_ofs) && $stable(m_last))
        else $error("result changed while stalled");

    // one request at a time: no input taken while results are pending
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // an input transfer is followed by a cycle with neither side open
    a_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !m_valid)
        else $error("unexpected handshake after input transfer");

    // status rows are single, empty and final
    a_status_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_NOTHING || m_status == ST_REJECT)
            |-> m_last && m_piece_len == '0 && !m_whole_block)
        else $error("malformed status row");

    // a move piece always carries bytes
    a_piece_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_PIECE |-> m_piece_len != '0)
        else $error("empty move piece");

endmodule

bind overlap_safe_block_move_splitter_top osbms_checker u_osbms_checker (.*);
